>>> hdl/wl512_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// wl512_pkg: shared constants and types for the WELL512a generator.
// No dependencies; used by every module under hdl/.

package wl512_pkg;

   localparam int WORD_W     = 32;
   localparam int POOL_DEPTH = 16;
   localparam int POS_W      = $clog2(POOL_DEPTH);
   localparam int ACTION_W   = 2;

   // Recurrence taps and constants
   localparam int TAP_M1 = 13;
   localparam int TAP_M2 = 9;
   localparam logic [WORD_W-1:0] TEMPER_MASK = 32'hDA44_2D24;
   localparam logic [WORD_W-1:0] SEED_MULT   = 32'd1812433253;

   // Action codes
   localparam logic [ACTION_W-1:0] ACT_GENERATE = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SEED     = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_LOAD     = 2'd2;

   // Sequencer states
   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SEED   = 2'd1;
   localparam logic [1:0] ST_ROTATE = 2'd2;

   typedef logic [WORD_W-1:0] word_type;

   // Per-cell control: shift toward cell 0, shift toward cell 15, or write
   typedef struct packed {
      logic shift_left;
      logic shift_right;
      logic write;
   } cell_ctrl_type;

endpackage

`default_nettype wire

>>> hdl/well512_random_generator.sv
`timescale 1ns / 1ps
`default_nettype none
// well512_random_generator: top level of the WELL512a generator.
// Depends on wl512_pkg, wl512_cell and wl512_step.
//
//  Channel   Ports                                   Direction  Moves
//  req       req_valid/ready, action, value, index   in         one command word
//  rsp       rsp_valid/ready, random_word            out        one random word
//
// Generate registers its word; a new word can be accepted every cycle while the
// result register drains. The pool lives in a ring of 16 cells aligned so that
// cell 0 always holds the current position; a generate shifts the ring by one.
// Seed: the value enters cell 15 on accept, then one multiply per cycle, each
// result shifted into cell 15, until all 16 cells hold seeded words.
// Load writes the addressed cell on accept, then realigns the ring if needed.
// Input stalls while seeding, realigning, or while an unread result is held.
// Reset is synchronous and clears the position and handshake state; after
// reset the ring shifts zeros into every cell and the input is held off.

module well512_random_generator (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic [wl512_pkg::ACTION_W-1:0]    req_action,
   input  wire logic [wl512_pkg::WORD_W-1:0]      req_value,
   input  wire logic [wl512_pkg::POS_W-1:0]       req_word_index,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic [wl512_pkg::WORD_W-1:0]           rsp_random_word
);

   localparam int DEPTH = wl512_pkg::POOL_DEPTH;
   localparam int PW    = wl512_pkg::POS_W;

   wl512_pkg::word_type      words [DEPTH];
   wl512_pkg::cell_ctrl_type ctrl  [DEPTH];

   logic [1:0]    state_ff, state_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [PW-1:0] cnt_ff, cnt_in;
   logic          rsp_valid_ff, rsp_valid_in;
   wl512_pkg::word_type rsp_word_ff, rsp_word_in;
   logic          clear_ff, clear_in;

   logic          req_acc;
   logic          gen_go, seed_go, load_go;
   logic          shl, shr;
   logic [PW-1:0] load_cell;
   wl512_pkg::word_type step_new_p, step_new_prev;
   wl512_pkg::word_type seed_mix, seed_prod, seed_next, tail_in;

   // Handshake decode
   assign req_ready = (state_ff == wl512_pkg::ST_IDLE) && !clear_ff
                      && (!rsp_valid_ff || rsp_ready);
   assign req_acc = req_valid && req_ready;
   assign gen_go  = req_acc && (req_action == wl512_pkg::ACT_GENERATE);
   assign seed_go = req_acc && (req_action == wl512_pkg::ACT_SEED);
   assign load_go = req_acc && (req_action == wl512_pkg::ACT_LOAD);

   // Recurrence on fixed taps of the ring
   wl512_step u_step (
      .tap_p    (words[0]),
      .tap_m1   (words[wl512_pkg::TAP_M1]),
      .tap_m2   (words[wl512_pkg::TAP_M2]),
      .tap_prev (words[DEPTH-1]),
      .new_p    (step_new_p),
      .new_prev (step_new_prev)
   );

   // Seed chain: next word from the one last shifted into cell 15
   assign seed_mix  = words[DEPTH-1] ^ (words[DEPTH-1] >> 30);
   assign seed_prod = wl512_pkg::SEED_MULT * seed_mix;
   assign seed_next = seed_prod + {{(wl512_pkg::WORD_W-PW){1'b0}}, cnt_ff};

   // Word entering cell 15 on a left shift
   always_comb begin
      case (state_ff)
         wl512_pkg::ST_SEED:   tail_in = seed_next;
         wl512_pkg::ST_ROTATE: tail_in = words[0];
         default:              tail_in = clear_ff ? '0 : req_value;
      endcase
   end

   // During the post-reset clear pass the ring shifts in zeros
   assign shl = seed_go || clear_ff || (state_ff == wl512_pkg::ST_SEED)
                || (state_ff == wl512_pkg::ST_ROTATE);
   assign shr = gen_go;
   assign load_cell = PW'(req_word_index - pos_ff);

   // Ring of cells; cell k holds W[(pos + k) mod 16]
   for (genvar k = 0; k < DEPTH; k++) begin : g_cell
      wl512_pkg::word_type from_left;
      wl512_pkg::word_type from_right;

      if (k == 0) begin : g_l0
         assign from_left = step_new_prev;
      end else if (k == 1) begin : g_l1
         assign from_left = step_new_p;
      end else begin : g_ln
         assign from_left = words[k-1];
      end

      if (k == DEPTH-1) begin : g_rt
         assign from_right = tail_in;
      end else begin : g_rn
         assign from_right = words[k+1];
      end

      assign ctrl[k].shift_left  = shl;
      assign ctrl[k].shift_right = shr;
      assign ctrl[k].write       = load_go && (load_cell == PW'(k));

      wl512_cell u_cell (
         .clock      (clock),
         .ctrl       (ctrl[k]),
         .from_left  (from_left),
         .from_right (from_right),
         .write_data (req_value),
         .word_out   (words[k])
      );
   end

   // Sequencer and position
   always_comb begin
      state_in = state_ff;
      pos_in   = pos_ff;
      cnt_in   = cnt_ff;
      clear_in = clear_ff;
      case (state_ff)
         wl512_pkg::ST_IDLE: begin
            if (clear_ff) begin
               cnt_in = cnt_ff + PW'(1);
               if (cnt_ff == PW'(DEPTH-1)) begin
                  clear_in = 1'b0;
               end
            end else if (gen_go) begin
               pos_in = pos_ff - PW'(1);
            end else if (seed_go) begin
               state_in = wl512_pkg::ST_SEED;
               pos_in   = '0;
               cnt_in   = PW'(1);
            end else if (load_go && (pos_ff != '0)) begin
               state_in = wl512_pkg::ST_ROTATE;
            end
         end
         wl512_pkg::ST_SEED: begin
            cnt_in = cnt_ff + PW'(1);
            if (cnt_ff == PW'(DEPTH-1)) begin
               state_in = wl512_pkg::ST_IDLE;
            end
         end
         wl512_pkg::ST_ROTATE: begin
            pos_in = pos_ff + PW'(1);
            if (pos_ff == PW'(DEPTH-1)) begin
               state_in = wl512_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = wl512_pkg::ST_IDLE;
         end
      endcase
   end

   // Result register
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (gen_go) begin
         rsp_valid_in = 1'b1;
         rsp_word_in  = step_new_prev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wl512_pkg::ST_IDLE;
         pos_ff       <= '0;
         cnt_ff       <= '0;
         clear_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         cnt_ff       <= cnt_in;
         clear_ff     <= clear_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_random_word = rsp_word_ff;

   // Checks
   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      (state_ff != wl512_pkg::ST_IDLE) |-> !req_ready)
      else $error("input accepted while sequencer busy");

   a_rise_from_gen: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready
                                 && (req_action == wl512_pkg::ACT_GENERATE)))
      else $error("result without a generate");

   a_rotate_pos: assert property (@(posedge clock) disable iff (reset)
      (state_ff == wl512_pkg::ST_ROTATE) |-> (pos_ff != '0))
      else $error("ring realignment with position already zero");

   a_seed_done: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == wl512_pkg::ST_SEED) && (cnt_ff == PW'(DEPTH-1)))
      |=> ((state_ff == wl512_pkg::ST_IDLE) && (pos_ff == '0)))
      else $error("seed pass did not end aligned");

   a_rotate_done: assert property (@(posedge clock) disable iff (reset)
      $fell(state_ff == wl512_pkg::ST_ROTATE) |-> (pos_ff == '0))
      else $error("ring realignment ended misaligned");

endmodule

`default_nettype wire

>>> hdl/wl512_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// wl512_cell: one pool word of the generator chain.
// Depends on wl512_pkg.

module wl512_cell (
   input  wire logic                  clock,
   input  wire wl512_pkg::cell_ctrl_type ctrl,
   input  wire wl512_pkg::word_type   from_left,
   input  wire wl512_pkg::word_type   from_right,
   input  wire wl512_pkg::word_type   write_data,
   output wl512_pkg::word_type        word_out
);

   wl512_pkg::word_type word_ff;
   wl512_pkg::word_type word_in;

   // Next word: write wins, then the two shift directions
   always_comb begin
      word_in = word_ff;
      if (ctrl.write) begin
         word_in = write_data;
      end else if (ctrl.shift_right) begin
         word_in = from_left;
      end else if (ctrl.shift_left) begin
         word_in = from_right;
      end
   end

   // Payload register, no reset: the top level shifts zeros through after reset
   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word_out = word_ff;

endmodule

`default_nettype wire

>>> hdl/wl512_step.sv
`timescale 1ns / 1ps
`default_nettype none
// wl512_step: WELL512a recurrence on the chain taps, combinational.
// Depends on wl512_pkg.

module wl512_step (
   input  wire wl512_pkg::word_type tap_p,     // W[p]
   input  wire wl512_pkg::word_type tap_m1,    // W[p+13]
   input  wire wl512_pkg::word_type tap_m2,    // W[p+9]
   input  wire wl512_pkg::word_type tap_prev,  // W[p-1]
   output wl512_pkg::word_type      new_p,     // new W[p]
   output wl512_pkg::word_type      new_prev   // new W[p-1], the output word
);

   wl512_pkg::word_type b_w;
   wl512_pkg::word_type c_w;
   wl512_pkg::word_type d_w;

   // First half: mix W[p] with W[p+13], fold W[p+9]
   assign b_w   = tap_p ^ tap_m1 ^ (tap_p << 16) ^ (tap_m1 << 15);
   assign c_w   = tap_m2 ^ (tap_m2 >> 11);
   assign new_p = b_w ^ c_w;

   // Second half: tempered term and the word one position down
   assign d_w      = new_p ^ ((new_p << 5) & wl512_pkg::TEMPER_MASK);
   assign new_prev = tap_prev ^ b_w ^ d_w ^ (tap_prev << 2) ^ (b_w << 18)
                     ^ (c_w << 28);

endmodule

`default_nettype wire
